>>> sv/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg: shared types and constants of the grid cell binning unit
// Field widths, register codes, reset values, queue entry layout and the
// per-axis span classification shared by the front and the back.
// ----------------------------------------------------------------------------
package gcb_pkg;

  localparam int COORD_W = 24;
  localparam int SIZE_W  = COORD_W - 1;
  localparam int THR_W   = COORD_W + 3;
  localparam int ID_W    = 16;
  localparam int CIDX_W  = 6;
  localparam int AXIS_W  = 2;
  localparam int CNT_W   = 3 * AXIS_W;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int RIDX_W  = 3;

  typedef enum logic [RIDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_CELL_WIDTH  = 3'd3,
    REG_CELL_HEIGHT = 3'd4,
    REG_CELL_DEPTH  = 3'd5,
    REG_CELL_COUNTS = 3'd6
  } reg_idx_e;

  localparam logic [COORD_W-1:0] ORIGIN_X_RST    = COORD_W'(-524288);
  localparam logic [COORD_W-1:0] ORIGIN_Y_RST    = COORD_W'(-524288);
  localparam logic [COORD_W-1:0] ORIGIN_Z_RST    = COORD_W'(-128);
  localparam logic [SIZE_W-1:0]  CELL_WIDTH_RST  = SIZE_W'(256000);
  localparam logic [SIZE_W-1:0]  CELL_HEIGHT_RST = SIZE_W'(256000);
  localparam logic [SIZE_W-1:0]  CELL_DEPTH_RST  = SIZE_W'(256);
  localparam logic [CNT_W-1:0]   CELL_COUNTS_RST = CNT_W'(15);

  // Grid corner plus -1, 1, 2, 3 and 4 cell sizes along one axis.
  typedef struct packed {
    logic signed [THR_W-1:0] t_neg;
    logic signed [THR_W-1:0] t1;
    logic signed [THR_W-1:0] t2;
    logic signed [THR_W-1:0] t3;
    logic signed [THR_W-1:0] t4;
  } axis_thr_t;

  typedef struct packed {
    axis_thr_t          x;
    axis_thr_t          y;
    axis_thr_t          z;
    logic [CNT_W-1:0]   counts;
  } grid_cfg_t;

  typedef struct packed {
    logic [AXIS_W-1:0] lo;
    logic [AXIS_W-1:0] hi;
    logic              none;
  } axis_span_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [AXIS_W-1:0] x0;
    logic [AXIS_W-1:0] x1;
    logic [AXIS_W-1:0] y0;
    logic [AXIS_W-1:0] y1;
    logic [AXIS_W-1:0] z0;
    logic [AXIS_W-1:0] z1;
    logic [AXIS_W-1:0] cx_m1;
    logic [AXIS_W-1:0] cy_m1;
  } bin_entry_t;

  // The quotient only matters up to 4 cells, so the division reduces to
  // comparisons against precomputed multiples of the cell size.
  function automatic axis_span_t axis_span(input logic [COORD_W-1:0] lo_c,
                                           input logic [COORD_W-1:0] hi_c,
                                           input axis_thr_t          thr,
                                           input logic [AXIS_W-1:0]  cnt_m1);
    logic signed [THR_W-1:0] lo_e;
    logic signed [THR_W-1:0] hi_e;
    logic [2:0]              lo_n;
    logic [2:0]              hi_n;
    logic                    hi_neg;
    axis_span_t              s;
    lo_e   = signed'({{(THR_W-COORD_W){lo_c[COORD_W-1]}}, lo_c});
    hi_e   = signed'({{(THR_W-COORD_W){hi_c[COORD_W-1]}}, hi_c});
    lo_n   = 3'(lo_e >= thr.t1) + 3'(lo_e >= thr.t2) + 3'(lo_e >= thr.t3)
           + 3'(lo_e >= thr.t4);
    hi_n   = 3'(hi_e >= thr.t1) + 3'(hi_e >= thr.t2) + 3'(hi_e >= thr.t3)
           + 3'(hi_e >= thr.t4);
    hi_neg = (hi_e <= thr.t_neg);
    s.lo   = lo_n[AXIS_W-1:0];
    s.hi   = (hi_n > {1'b0, cnt_m1}) ? cnt_m1 : hi_n[AXIS_W-1:0];
    s.none = lo_n[2] || hi_neg || (s.lo > s.hi);
    return s;
  endfunction

endpackage

>>> sv/gcb_cfg.sv
// ----------------------------------------------------------------------------
// gcb_cfg: configuration registers
// APB-style register file holding the grid origin, cell sizes and counts,
// and registered per-axis comparison thresholds derived from them.
// ----------------------------------------------------------------------------
module gcb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcb_pkg::ADDR_W-1:0]    paddr,
  input  logic [gcb_pkg::DATA_W-1:0]    pwdata,
  output logic [gcb_pkg::DATA_W-1:0]    prdata,
  output gcb_pkg::grid_cfg_t            cfg_o
);

  localparam int CW = gcb_pkg::COORD_W;
  localparam int SW = gcb_pkg::SIZE_W;

  logic [CW-1:0]               origin_x_q, origin_y_q, origin_z_q;
  logic [SW-1:0]               width_q, height_q, depth_q;
  logic [SW+1:0]               width3_q, height3_q, depth3_q;
  logic [gcb_pkg::CNT_W-1:0]   counts_q;
  gcb_pkg::axis_thr_t          thr_x_q, thr_y_q, thr_z_q;

  logic                        wr_en;
  gcb_pkg::reg_idx_e           widx;
  logic [SW-1:0]               wsize;
  logic [SW-1:0]               wsize_eff;
  logic [SW+1:0]               wsize3;

  function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] s);
    return (s == '0) ? SW'(1) : s;
  endfunction

  function automatic gcb_pkg::axis_thr_t axis_thr(input logic [CW-1:0] org,
                                                  input logic [SW-1:0] size,
                                                  input logic [SW+1:0] size3);
    logic signed [gcb_pkg::THR_W-1:0] o;
    logic [SW-1:0]                    e;
    gcb_pkg::axis_thr_t               t;
    o       = signed'({{(gcb_pkg::THR_W-CW){org[CW-1]}}, org});
    e       = eff_size(size);
    t.t_neg = o - signed'(gcb_pkg::THR_W'(e));
    t.t1    = o + signed'(gcb_pkg::THR_W'(e));
    t.t2    = o + signed'(gcb_pkg::THR_W'({e, 1'b0}));
    t.t3    = o + signed'(gcb_pkg::THR_W'(size3));
    t.t4    = o + signed'(gcb_pkg::THR_W'({e, 2'b00}));
    return t;
  endfunction

  assign wr_en     = psel && penable && pwrite;
  assign widx      = gcb_pkg::reg_idx_e'(paddr[gcb_pkg::ADDR_W-1:2]);
  assign wsize     = pwdata[SW-1:0];
  assign wsize_eff = eff_size(wsize);
  // Three times the size is formed at write time so the threshold path is one add.
  assign wsize3    = (SW+2)'(wsize_eff) + (SW+2)'({wsize_eff, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= gcb_pkg::ORIGIN_X_RST;
      origin_y_q <= gcb_pkg::ORIGIN_Y_RST;
      origin_z_q <= gcb_pkg::ORIGIN_Z_RST;
      width_q    <= gcb_pkg::CELL_WIDTH_RST;
      height_q   <= gcb_pkg::CELL_HEIGHT_RST;
      depth_q    <= gcb_pkg::CELL_DEPTH_RST;
      width3_q   <= (SW+2)'(3 * 256000);
      height3_q  <= (SW+2)'(3 * 256000);
      depth3_q   <= (SW+2)'(3 * 256);
      counts_q   <= gcb_pkg::CELL_COUNTS_RST;
    end else if (wr_en) begin
      case (widx)
        gcb_pkg::REG_ORIGIN_X:    origin_x_q <= pwdata[CW-1:0];
        gcb_pkg::REG_ORIGIN_Y:    origin_y_q <= pwdata[CW-1:0];
        gcb_pkg::REG_ORIGIN_Z:    origin_z_q <= pwdata[CW-1:0];
        gcb_pkg::REG_CELL_WIDTH: begin
          width_q  <= wsize;
          width3_q <= wsize3;
        end
        gcb_pkg::REG_CELL_HEIGHT: begin
          height_q  <= wsize;
          height3_q <= wsize3;
        end
        gcb_pkg::REG_CELL_DEPTH: begin
          depth_q  <= wsize;
          depth3_q <= wsize3;
        end
        gcb_pkg::REG_CELL_COUNTS: counts_q <= pwdata[gcb_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Refreshed every cycle; a beat accepted right after a write is compared
  // once its box is registered, by which time these hold the new values.
  always_ff @(posedge clk_i) begin
    thr_x_q <= axis_thr(origin_x_q, width_q, width3_q);
    thr_y_q <= axis_thr(origin_y_q, height_q, height3_q);
    thr_z_q <= axis_thr(origin_z_q, depth_q, depth3_q);
  end

  always_comb begin
    case (widx)
      gcb_pkg::REG_ORIGIN_X:    prdata = {{(gcb_pkg::DATA_W-CW){origin_x_q[CW-1]}}, origin_x_q};
      gcb_pkg::REG_ORIGIN_Y:    prdata = {{(gcb_pkg::DATA_W-CW){origin_y_q[CW-1]}}, origin_y_q};
      gcb_pkg::REG_ORIGIN_Z:    prdata = {{(gcb_pkg::DATA_W-CW){origin_z_q[CW-1]}}, origin_z_q};
      gcb_pkg::REG_CELL_WIDTH:  prdata = gcb_pkg::DATA_W'(width_q);
      gcb_pkg::REG_CELL_HEIGHT: prdata = gcb_pkg::DATA_W'(height_q);
      gcb_pkg::REG_CELL_DEPTH:  prdata = gcb_pkg::DATA_W'(depth_q);
      gcb_pkg::REG_CELL_COUNTS: prdata = gcb_pkg::DATA_W'(counts_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.x      = thr_x_q;
  assign cfg_o.y      = thr_y_q;
  assign cfg_o.z      = thr_z_q;
  assign cfg_o.counts = counts_q;

endmodule

>>> sv/gcb_front.sv
// ----------------------------------------------------------------------------
// gcb_front: input stage and classification
// Registers each box, turns its corners into clamped cell ranges per axis,
// drops boxes that cover no cell and pushes the rest into the queue.
// ----------------------------------------------------------------------------
module gcb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gcb_pkg::ID_W-1:0]      collider_id_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_min_x_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_min_y_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_min_z_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_max_x_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_max_y_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_max_z_i,
  input  gcb_pkg::grid_cfg_t            cfg_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output gcb_pkg::bin_entry_t           entry_o
);

  localparam int CW = gcb_pkg::COORD_W;
  localparam int AW = gcb_pkg::AXIS_W;

  logic                       valid_q, valid_d;
  logic [gcb_pkg::ID_W-1:0]   id_q;
  logic [CW-1:0]              min_x_q, min_y_q, min_z_q;
  logic [CW-1:0]              max_x_q, max_y_q, max_z_q;
  gcb_pkg::axis_span_t        span_x, span_y, span_z;
  logic                       none;
  logic                       go;
  logic                       take;

  assign span_x = gcb_pkg::axis_span(min_x_q, max_x_q, cfg_i.x, cfg_i.counts[AW-1:0]);
  assign span_y = gcb_pkg::axis_span(min_y_q, max_y_q, cfg_i.y, cfg_i.counts[2*AW-1:AW]);
  assign span_z = gcb_pkg::axis_span(min_z_q, max_z_q, cfg_i.z, cfg_i.counts[3*AW-1:2*AW]);
  assign none   = span_x.none || span_y.none || span_z.none;

  // A box that covers no cell leaves without a queue slot.
  assign go         = valid_q && (none || !q_full_i);
  assign push_o     = valid_q && !none && !q_full_i;
  assign in_ready_o = !valid_q || go;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (go) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      id_q    <= collider_id_i;
      min_x_q <= box_min_x_i;
      min_y_q <= box_min_y_i;
      min_z_q <= box_min_z_i;
      max_x_q <= box_max_x_i;
      max_y_q <= box_max_y_i;
      max_z_q <= box_max_z_i;
    end
  end

  assign entry_o.id    = id_q;
  assign entry_o.x0    = span_x.lo;
  assign entry_o.x1    = span_x.hi;
  assign entry_o.y0    = span_y.lo;
  assign entry_o.y1    = span_y.hi;
  assign entry_o.z0    = span_z.lo;
  assign entry_o.z1    = span_z.hi;
  assign entry_o.cx_m1 = cfg_i.counts[AW-1:0];
  assign entry_o.cy_m1 = cfg_i.counts[2*AW-1:AW];

endmodule

>>> sv/gcb_fifo.sv
// ----------------------------------------------------------------------------
// gcb_fifo: classified box queue
// Small register queue between the front and the back so that each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module gcb_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  gcb_pkg::bin_entry_t   entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output gcb_pkg::bin_entry_t   head_o
);

  localparam int PW = gcb_pkg::QPTR_W;

  gcb_pkg::bin_entry_t   mem_q [gcb_pkg::QDEPTH];
  logic [PW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [PW:0]           cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(gcb_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> sv/gcb_back.sv
// ----------------------------------------------------------------------------
// gcb_back: cell enumerator
// Walks the cell range of the box at the queue head, x fastest, then y,
// then z, and places one cell beat per cycle into the output register while the receiver takes them.
// ----------------------------------------------------------------------------
module gcb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  gcb_pkg::bin_entry_t           head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gcb_pkg::ID_W-1:0]      owner_id_o,
  output logic [gcb_pkg::CIDX_W-1:0]    cell_index_o,
  output logic                          last_cell_o
);

  localparam int AW = gcb_pkg::AXIS_W;

  logic                         started_q, started_d;
  logic [AW-1:0]                x_q, y_q, z_q;
  logic [AW-1:0]                x_d, y_d, z_d;
  logic [AW-1:0]                cur_x, cur_y, cur_z;
  logic                         out_valid_q, out_valid_d;
  logic [gcb_pkg::ID_W-1:0]     owner_q;
  logic [gcb_pkg::CIDX_W-1:0]   index_q, index_d;
  logic                         last_q;
  logic                         adv, last;
  logic [AW:0]                  cx, cy;
  logic [2*AW:0]                cxy;
  logic [3*AW+1:0]              sum;

  // The first cell of a box starts at its lower corner straight from the head.
  assign cur_x = started_q ? x_q : head_i.x0;
  assign cur_y = started_q ? y_q : head_i.y0;
  assign cur_z = started_q ? z_q : head_i.z0;

  assign adv   = head_valid_i && (!out_valid_q || out_ready_i);
  assign last  = (cur_x == head_i.x1) && (cur_y == head_i.y1) && (cur_z == head_i.z1);
  assign pop_o = adv && last;

  assign cx      = {1'b0, head_i.cx_m1} + 1'b1;
  assign cy      = {1'b0, head_i.cy_m1} + 1'b1;
  assign cxy     = (2*AW+1)'(cx) * (2*AW+1)'(cy);
  assign sum     = (3*AW+2)'(cur_z) * (3*AW+2)'(cxy)
                 + (3*AW+2)'(cur_y) * (3*AW+2)'(cx)
                 + (3*AW+2)'(cur_x);
  assign index_d = sum[gcb_pkg::CIDX_W-1:0];

  always_comb begin
    x_d = cur_x;
    y_d = cur_y;
    z_d = cur_z;
    if (cur_x != head_i.x1) begin
      x_d = cur_x + 1'b1;
    end else begin
      x_d = head_i.x0;
      if (cur_y != head_i.y1) begin
        y_d = cur_y + 1'b1;
      end else begin
        y_d = head_i.y0;
        z_d = cur_z + 1'b1;
      end
    end
  end

  always_comb begin
    started_d   = started_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      started_d   = !last;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      owner_q <= head_i.id;
      index_q <= index_d;
      last_q  <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign owner_id_o   = owner_q;
  assign cell_index_o = index_q;
  assign last_cell_o  = last_q;

endmodule

>>> sv/grid_cell_binning_unit.sv
// ----------------------------------------------------------------------------
// grid_cell_binning_unit: uniform grid broad-phase binning
// A collider box beat goes in on the input channel; one beat per overlapped
// grid cell comes out, carrying the collider id, the linear cell index
// (z*cx*cy + y*cx + x, x fastest) and a flag on the last cell of the box.
// A box that overlaps no cell produces no output beat at all.
// The grid origin, cell sizes and cell counts sit in APB registers at byte
// offsets 0x00 to 0x18; write them only while no box is in flight.
// Path: an accepted box is held in the front's input register and then in
// the queue; its first cell beat comes out of the enumerator's output register.
// Throughput: the output register takes one cell beat per cycle while the
// receiver is ready, so the enumerator spends one beat on each cell a box covers;
// the front takes a new box every cycle while the four-entry queue has room.
// A stalled receiver holds the output beat; the enumerator and then the queue
// and the front fill up behind it and in_ready_o falls only when all are full.
// Reset empties the pipeline and loads the default grid of 4 x 4 x 1 cells.
// ----------------------------------------------------------------------------
module grid_cell_binning_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcb_pkg::ADDR_W-1:0]    paddr,
  input  logic [gcb_pkg::DATA_W-1:0]    pwdata,
  output logic [gcb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gcb_pkg::ID_W-1:0]      collider_id_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_min_x_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_min_y_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_min_z_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_max_x_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_max_y_i,
  input  logic [gcb_pkg::COORD_W-1:0]   box_max_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gcb_pkg::ID_W-1:0]      owner_id_o,
  output logic [gcb_pkg::CIDX_W-1:0]    cell_index_o,
  output logic                          last_cell_o
);

  gcb_pkg::grid_cfg_t    cfg;
  gcb_pkg::bin_entry_t   push_entry;
  gcb_pkg::bin_entry_t   head;
  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;

  assign pready = 1'b1;

  gcb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  gcb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .collider_id_i (collider_id_i),
    .box_min_x_i   (box_min_x_i),
    .box_min_y_i   (box_min_y_i),
    .box_min_z_i   (box_min_z_i),
    .box_max_x_i   (box_max_x_i),
    .box_max_y_i   (box_max_y_i),
    .box_max_z_i   (box_max_z_i),
    .cfg_i         (cfg),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  gcb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  gcb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .owner_id_o   (owner_id_o),
    .cell_index_o (cell_index_o),
    .last_cell_o  (last_cell_o)
  );

endmodule
